// ===== rtl/irq_source_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Interrupt source block allocator assertion macros
// Shared assertion shorthands for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef IRQ_SOURCE_BLOCK_ALLOCATOR_MACROS_SVH
`define IRQ_SOURCE_BLOCK_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ISBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/isba_pkg.sv =====
// ----------------------------------------------------------------------------
// Interrupt source block allocator package
// Sizes, codes and interface structs shared by the allocator modules.
// ----------------------------------------------------------------------------
package isba_pkg;

   localparam int NR_SOURCES        = 1024;
   localparam int IDX_W             = $clog2(NR_SOURCES);
   localparam int CNT_W             = IDX_W + 1;
   localparam int NUM_W             = 16;
   localparam int COUNT_W           = 11;
   localparam int SUM_W             = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
   localparam int KIND_W            = 2;
   localparam int MAX_ALIGNED_COUNT = 32;
   localparam logic [NUM_W-1:0] OFFSET_RESET = 16'h1000;

   typedef enum logic [1:0] {
      CMD_FIND  = 2'd0,
      CMD_CLAIM = 2'd1,
      CMD_FREE  = 2'd2
   } isba_cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_BUSY     = 2'd2,
      STATUS_NO_BLOCK = 2'd3
   } isba_status_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_FREE  = 2'd0,
      KIND_MSG   = 2'd1,
      KIND_LEVEL = 2'd2
   } isba_kind_type;

   typedef enum logic [2:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_FIND,
      STATE_CLAIM_RD,
      STATE_CLAIM_CHK,
      STATE_FREE,
      STATE_DONE
   } isba_state_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [NUM_W-1:0]   irq_number;
      logic [COUNT_W-1:0] count;
      logic               align;
      logic               level_type;
   } isba_req_type;

   typedef struct packed {
      logic               valid;
      isba_status_type    status;
      logic [NUM_W-1:0]   found_irq;
   } isba_done_type;

   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [KIND_W-1:0]  wdata;
      logic               re;
      logic [IDX_W-1:0]   raddr;
   } isba_mem_req_type;

endpackage

// ===== rtl/isba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module isba_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/isba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the source table one entry per cycle for clear, find and free; a claim reads and updates a single entry.
// ----------------------------------------------------------------------------
module isba_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  isba_pkg::isba_req_type          req,
   input  logic [isba_pkg::NUM_W-1:0]      irq_offset,
   input  logic                            out_free,
   output isba_pkg::isba_done_type         done,
   output isba_pkg::isba_mem_req_type      mem,
   input  logic [isba_pkg::KIND_W-1:0]     mem_rdata
);

   isba_pkg::isba_state_type          state_ff, state_in;
   logic [isba_pkg::CNT_W-1:0]        ptr_ff, ptr_in;
   logic [isba_pkg::CNT_W-1:0]        lim_ff, lim_in;
   logic [isba_pkg::SUM_W-1:0]        start_ff, start_in;
   logic [isba_pkg::IDX_W-1:0]        chk_addr_ff, chk_addr_in;
   logic                              chk_vld_ff, chk_vld_in;
   logic [isba_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                              align_ff, align_in;
   logic                              level_ff, level_in;
   isba_pkg::isba_status_type         res_status_ff, res_status_in;
   logic [isba_pkg::NUM_W-1:0]        res_found_ff, res_found_in;

   logic [isba_pkg::NUM_W:0]          diff;
   logic                              in_tab;
   logic [isba_pkg::SUM_W-1:0]        free_end;
   logic                              pow2_ok;
   logic [isba_pkg::SUM_W-1:0]        cnt_ext;
   logic [isba_pkg::SUM_W-1:0]        chk_ext;
   logic [isba_pkg::SUM_W-1:0]        run_end;
   logic [isba_pkg::SUM_W-1:0]        next_start;

   // Table lookup of a global number, and validity of an aligned count.
   always_comb begin
      diff     = {1'b0, req.irq_number} - {1'b0, irq_offset};
      in_tab   = !diff[isba_pkg::NUM_W] &&
                 (diff[isba_pkg::NUM_W-1:0] < isba_pkg::NUM_W'(isba_pkg::NR_SOURCES));
      free_end = isba_pkg::SUM_W'(diff[isba_pkg::IDX_W-1:0]) + isba_pkg::SUM_W'(req.count);
      pow2_ok  = (req.count <= isba_pkg::COUNT_W'(isba_pkg::MAX_ALIGNED_COUNT)) &&
                 ((req.count & (req.count - 1'b1)) == '0);
   end

   // Run tracking for the find scan.
   always_comb begin
      cnt_ext = isba_pkg::SUM_W'(count_ff);
      chk_ext = isba_pkg::SUM_W'(chk_addr_ff);
      run_end = start_ff + cnt_ext;
      if (align_ff) begin
         next_start = (chk_ext & ~(cnt_ext - 1'b1)) + cnt_ext;
      end else begin
         next_start = chk_ext + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= isba_pkg::STATE_CLEAR;
         ptr_ff     <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ptr_ff     <= ptr_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff        <= lim_in;
      start_ff      <= start_in;
      chk_addr_ff   <= chk_addr_in;
      count_ff      <= count_in;
      align_ff      <= align_in;
      level_ff      <= level_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
   end

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      lim_in        = lim_ff;
      start_in      = start_ff;
      chk_addr_in   = chk_addr_ff;
      chk_vld_in    = 1'b0;
      count_in      = count_ff;
      align_in      = align_ff;
      level_in      = level_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      req_ready     = 1'b0;
      done          = '0;
      mem           = '0;
      mem.wdata     = isba_pkg::KIND_FREE;

      unique case (state_ff)
         isba_pkg::STATE_CLEAR: begin
            mem.we    = 1'b1;
            mem.waddr = ptr_ff[isba_pkg::IDX_W-1:0];
            ptr_in    = ptr_ff + 1'b1;
            if (ptr_ff == isba_pkg::CNT_W'(isba_pkg::NR_SOURCES - 1)) begin
               state_in = isba_pkg::STATE_IDLE;
            end
         end

         isba_pkg::STATE_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               count_in      = req.count;
               align_in      = req.align;
               level_in      = req.level_type;
               res_found_in  = '0;
               res_status_in = isba_pkg::STATUS_INVALID;
               state_in      = isba_pkg::STATE_DONE;
               unique case (isba_pkg::isba_cmd_type'(req.command))
                  isba_pkg::CMD_FIND: begin
                     ptr_in   = '0;
                     start_in = '0;
                     priority if (req.count == '0) begin
                        res_status_in = isba_pkg::STATUS_INVALID;
                     end else if (req.align && !pow2_ok) begin
                        res_status_in = isba_pkg::STATUS_INVALID;
                     end else if (isba_pkg::SUM_W'(req.count) >
                                  isba_pkg::SUM_W'(isba_pkg::NR_SOURCES)) begin
                        res_status_in = isba_pkg::STATUS_NO_BLOCK;
                     end else begin
                        state_in = isba_pkg::STATE_FIND;
                     end
                  end
                  isba_pkg::CMD_CLAIM: begin
                     if (in_tab) begin
                        ptr_in   = isba_pkg::CNT_W'(diff[isba_pkg::IDX_W-1:0]);
                        state_in = isba_pkg::STATE_CLAIM_RD;
                     end
                  end
                  isba_pkg::CMD_FREE: begin
                     if (in_tab) begin
                        res_status_in = isba_pkg::STATUS_OK;
                        ptr_in        = isba_pkg::CNT_W'(diff[isba_pkg::IDX_W-1:0]);
                        // The run is clamped at the end of the table.
                        if (free_end > isba_pkg::SUM_W'(isba_pkg::NR_SOURCES)) begin
                           lim_in = isba_pkg::CNT_W'(isba_pkg::NR_SOURCES);
                        end else begin
                           lim_in = free_end[isba_pkg::CNT_W-1:0];
                        end
                        if (req.count != '0) begin
                           state_in = isba_pkg::STATE_FREE;
                        end
                     end
                  end
                  default: begin
                     res_status_in = isba_pkg::STATUS_INVALID;
                  end
               endcase
            end
         end

         isba_pkg::STATE_FIND: begin
            // Each entry is checked in the cycle after its read is issued.
            if (ptr_ff < isba_pkg::CNT_W'(isba_pkg::NR_SOURCES)) begin
               mem.re      = 1'b1;
               mem.raddr   = ptr_ff[isba_pkg::IDX_W-1:0];
               ptr_in      = ptr_ff + 1'b1;
               chk_vld_in  = 1'b1;
               chk_addr_in = ptr_ff[isba_pkg::IDX_W-1:0];
            end
            priority if (run_end > isba_pkg::SUM_W'(isba_pkg::NR_SOURCES)) begin
               res_status_in = isba_pkg::STATUS_NO_BLOCK;
               state_in      = isba_pkg::STATE_DONE;
            end else if (chk_vld_ff && (chk_ext >= start_ff)) begin
               if (mem_rdata != isba_pkg::KIND_FREE) begin
                  start_in = next_start;
               end else if (chk_ext + 1'b1 == run_end) begin
                  res_status_in = isba_pkg::STATUS_OK;
                  res_found_in  = irq_offset + isba_pkg::NUM_W'(start_ff);
                  state_in      = isba_pkg::STATE_DONE;
               end
            end else begin
               start_in = start_ff;
            end
         end

         isba_pkg::STATE_CLAIM_RD: begin
            mem.re    = 1'b1;
            mem.raddr = ptr_ff[isba_pkg::IDX_W-1:0];
            state_in  = isba_pkg::STATE_CLAIM_CHK;
         end

         isba_pkg::STATE_CLAIM_CHK: begin
            state_in = isba_pkg::STATE_DONE;
            if (mem_rdata != isba_pkg::KIND_FREE) begin
               res_status_in = isba_pkg::STATUS_BUSY;
            end else begin
               mem.we        = 1'b1;
               mem.waddr     = ptr_ff[isba_pkg::IDX_W-1:0];
               mem.wdata     = level_ff ? isba_pkg::KIND_LEVEL : isba_pkg::KIND_MSG;
               res_status_in = isba_pkg::STATUS_OK;
            end
         end

         isba_pkg::STATE_FREE: begin
            mem.we    = 1'b1;
            mem.waddr = ptr_ff[isba_pkg::IDX_W-1:0];
            ptr_in    = ptr_ff + 1'b1;
            if (ptr_in >= lim_ff) begin
               state_in = isba_pkg::STATE_DONE;
            end
         end

         isba_pkg::STATE_DONE: begin
            if (out_free) begin
               done.valid     = 1'b1;
               done.status    = res_status_ff;
               done.found_irq = res_found_ff;
               state_in       = isba_pkg::STATE_IDLE;
            end
         end

         default: begin
            state_in = isba_pkg::STATE_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/irq_source_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Interrupt source block allocator
// Table of interrupt sources with first-fit block find, claim and free.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports
// req       in         req_command, req_irq_number, req_count, req_align,
//                      req_level_type
// rsp       out        rsp_status, rsp_found_irq
// csr       in         csr_wdata (irq_offset)
//
// After reset the table is cleared one entry per cycle, all 1024 entries, with
// req_ready low; csr writes are taken throughout.
// A find checks one entry per cycle through the one table read port. A claim
// reads its entry and writes it if free; a free clears its run of entries.
// The result sits in an output register, so a stalled rsp only holds the
// sequencer once its next result is ready.
// ----------------------------------------------------------------------------
`include "irq_source_block_allocator_macros.svh"

module irq_source_block_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_command,
   input  logic [isba_pkg::NUM_W-1:0]        req_irq_number,
   input  logic [isba_pkg::COUNT_W-1:0]      req_count,
   input  logic                              req_align,
   input  logic                              req_level_type,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [isba_pkg::NUM_W-1:0]        rsp_found_irq,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [isba_pkg::NUM_W-1:0]        csr_wdata
);

   logic [isba_pkg::NUM_W-1:0]    irq_offset_ff, irq_offset_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;
   logic [isba_pkg::NUM_W-1:0]    rsp_found_ff, rsp_found_in;
   logic                          out_free;
   isba_pkg::isba_req_type        req;
   isba_pkg::isba_done_type       done;
   isba_pkg::isba_mem_req_type    mem;
   logic [isba_pkg::KIND_W-1:0]   mem_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      req.command    = req_command;
      req.irq_number = req_irq_number;
      req.count      = req_count;
      req.align      = req_align;
      req.level_type = req_level_type;
   end

   // The output slot is free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      irq_offset_in = irq_offset_ff;
      if (csr_valid && csr_ready) begin
         irq_offset_in = csr_wdata;
      end
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      if (done.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = done.status;
         rsp_found_in  = done.found_irq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_offset_ff <= isba_pkg::OFFSET_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         irq_offset_ff <= irq_offset_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found_irq = rsp_found_ff;

   isba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .irq_offset (irq_offset_ff),
      .out_free   (out_free),
      .done       (done),
      .mem        (mem),
      .mem_rdata  (mem_rdata)
   );

   isba_ram #(
      .WIDTH (isba_pkg::KIND_W),
      .DEPTH (isba_pkg::NR_SOURCES)
   ) u_table (
      .clock (clock),
      .we    (mem.we),
      .waddr (mem.waddr),
      .wdata (mem.wdata),
      .re    (mem.re),
      .raddr (mem.raddr),
      .rdata (mem_rdata)
   );

   `ISBA_ASSERT_NOW(a_no_overwrite, clock, reset, done.valid, out_free, "result overwrote a pending response")
   `ISBA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after a request transfer")
   `ISBA_ASSERT_NEXT(a_rsp_drains, clock, reset, rsp_valid && rsp_ready && !done.valid, !rsp_valid, "response stayed valid after its transfer")
   `ISBA_ASSERT_NOW(a_found_zero, clock, reset, rsp_valid && (rsp_status != isba_pkg::STATUS_OK), rsp_found_irq == '0, "found_irq nonzero on a failed command")

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Interrupt source block allocator testbench
// Drives find, claim, free and reserved requests through the request channel,
// and writes irq_offset on the csr channel. Typed directed rows are checked
// against their row, all other responses against a shadow copy of the source
// table kept in the testbench. A short directed table comes first, then random
// traffic under several offsets and patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
   import isba_pkg::*;

   localparam logic [1:0] CMD_RESERVED = 2'd3;

   typedef struct packed {
      isba_status_type    status;
      logic [NUM_W-1:0]   found_irq;
   } alloc_result_type;

   typedef struct {
      isba_req_type      req;
      bit                typed;
      alloc_result_type  want;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_command = CMD_FIND;
   logic [NUM_W-1:0]    req_irq_number = '0;
   logic [COUNT_W-1:0]  req_count = '0;
   logic                req_align = 1'b0;
   logic                req_level_type = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [1:0]          rsp_status;
   logic [NUM_W-1:0]    rsp_found_irq;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [NUM_W-1:0]    csr_wdata = '0;

   // Shadow of the allocator state.
   isba_kind_type       shadow_kind [NR_SOURCES];
   logic [NUM_W-1:0]    shadow_offset;

   alloc_result_type    awaited_results [$];
   alloc_result_type    oldest_result;

   int                  send_idle_pct = 30;
   int                  rsp_stall_pct = 69;
   int                  error_count = 0;
   int                  checked_count = 0;
   int                  find_count = 0;
   int                  claim_count = 0;
   int                  free_count = 0;
   int                  other_count = 0;
   int                  offset_writes = 0;

   irq_source_block_allocator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_irq_number (req_irq_number),
      .req_count      (req_count),
      .req_align      (req_align),
      .req_level_type (req_level_type),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_found_irq  (rsp_found_irq),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   // Applies one request to the shadow table and returns its response.
   function automatic alloc_result_type apply_allocation(isba_req_type r);
      alloc_result_type res;
      int cnt;
      int num;
      int base;
      int stride;
      int start;
      int stop;
      int i;
      bit hit;
      bit run_free;
      res.status = STATUS_INVALID;
      res.found_irq = '0;
      cnt = int'(r.count);
      num = int'(r.irq_number);
      base = int'(shadow_offset);
      case (r.command)
         CMD_FIND: begin
            if (cnt == 0) begin
               res.status = STATUS_INVALID;
            end else if (r.align && (cnt > MAX_ALIGNED_COUNT || (cnt & (cnt - 1)) != 0)) begin
               res.status = STATUS_INVALID;
            end else begin
               stride = r.align ? cnt : 1;
               res.status = STATUS_NO_BLOCK;
               hit = 1'b0;
               start = 0;
               while (!hit && start < NR_SOURCES && cnt <= NR_SOURCES - start) begin
                  run_free = 1'b1;
                  for (i = start; run_free && i < start + cnt; i++) begin
                     if (shadow_kind[i] != KIND_FREE) run_free = 1'b0;
                  end
                  if (run_free) begin
                     hit = 1'b1;
                     res.status = STATUS_OK;
                     res.found_irq = NUM_W'(start + base);
                  end else begin
                     start += stride;
                  end
               end
            end
         end
         CMD_CLAIM: begin
            if (num < base || num - base >= NR_SOURCES) begin
               res.status = STATUS_INVALID;
            end else if (shadow_kind[num - base] != KIND_FREE) begin
               res.status = STATUS_BUSY;
            end else begin
               shadow_kind[num - base] = r.level_type ? KIND_LEVEL : KIND_MSG;
               res.status = STATUS_OK;
            end
         end
         CMD_FREE: begin
            if (num < base || num - base >= NR_SOURCES) begin
               res.status = STATUS_INVALID;
            end else begin
               stop = num - base + cnt;
               if (stop > NR_SOURCES) stop = NR_SOURCES;
               for (i = num - base; i < stop; i++) shadow_kind[i] = KIND_FREE;
               res.status = STATUS_OK;
            end
         end
         default: begin
            res.status = STATUS_INVALID;
         end
      endcase
      if (res.status != STATUS_OK) res.found_irq = '0;
      return res;
   endfunction

   function automatic dir_row_type stim_row(logic [1:0] cmd, logic [NUM_W-1:0] num,
                                            logic [COUNT_W-1:0] cnt, bit al, bit lv, bit typed,
                                            isba_status_type st, logic [NUM_W-1:0] fnd);
      dir_row_type r;
      r.req.command = cmd;
      r.req.irq_number = num;
      r.req.count = cnt;
      r.req.align = al;
      r.req.level_type = lv;
      r.typed = typed;
      r.want.status = st;
      r.want.found_irq = fnd;
      return r;
   endfunction

   // Mostly well-formed traffic aimed at the low part of the table, so that
   // finds have to skip claimed entries; one request in five is raw noise.
   function automatic isba_req_type random_request();
      isba_req_type r;
      int pick;
      int entry;
      pick = $urandom_range(99);
      entry = $urandom_range(99);
      if (entry < 80) entry = $urandom_range(127);
      else if (entry < 95) entry = $urandom_range(NR_SOURCES - 1);
      else entry = $urandom_range(NR_SOURCES - 1, NR_SOURCES - 24);
      r.command = CMD_FIND;
      r.irq_number = shadow_offset + NUM_W'(entry);
      r.count = 1;
      r.align = 1'b0;
      r.level_type = 1'($urandom_range(1));
      if (pick < 35) begin
         r.command = CMD_CLAIM;
         r.count = COUNT_W'($urandom_range(2047));
         r.align = 1'($urandom_range(1));
      end else if (pick < 55) begin
         r.command = CMD_FREE;
         pick = $urandom_range(99);
         if (pick < 70) r.count = COUNT_W'($urandom_range(8, 1));
         else if (pick < 90) r.count = COUNT_W'($urandom_range(64, 1));
         else r.count = COUNT_W'($urandom_range(2047));
      end else if (pick < 80) begin
         r.command = CMD_FIND;
         r.irq_number = NUM_W'($urandom_range(65535));
         r.align = 1'($urandom_range(1));
         pick = $urandom_range(99);
         if (r.align) begin
            if (pick < 95) r.count = COUNT_W'(1 << $urandom_range(5));
            else r.count = COUNT_W'($urandom_range(2047));
         end else begin
            if (pick < 75) r.count = COUNT_W'($urandom_range(16, 1));
            else if (pick < 95) r.count = COUNT_W'($urandom_range(300, 1));
            else r.count = COUNT_W'($urandom_range(2047));
         end
      end else begin
         r.command = 2'($urandom_range(3));
         r.irq_number = NUM_W'($urandom_range(65535));
         r.count = COUNT_W'($urandom_range(2047));
         r.align = 1'($urandom_range(1));
      end
      return r;
   endfunction

   task automatic send_request(isba_req_type item, bit typed, alloc_result_type want);
      int gap;
      alloc_result_type predicted;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= item.command;
      req_irq_number <= item.irq_number;
      req_count <= item.count;
      req_align <= item.align;
      req_level_type <= item.level_type;
      do @(posedge clock); while (!req_ready);
      predicted = apply_allocation(item);
      awaited_results.push_back(typed ? want : predicted);
      case (item.command)
         CMD_FIND: find_count++;
         CMD_CLAIM: claim_count++;
         CMD_FREE: free_count++;
         default: other_count++;
      endcase
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_offset(logic [NUM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_offset = value;
      offset_writes++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("response transfer with no request outstanding");
         end else begin
            oldest_result = awaited_results.pop_front();
            checked_count++;
            if (rsp_status !== oldest_result.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status,
                                         oldest_result.status));
            if (rsp_found_irq !== oldest_result.found_irq)
               report_mismatch($sformatf("found_irq %0d, expected %0d", rsp_found_irq,
                                         oldest_result.found_irq));
         end
      end
   end

   initial begin : main_seq
      dir_row_type dir_rows [$];
      logic [NUM_W-1:0] chunk_offset [6];
      int k;
      int n;

      for (k = 0; k < NR_SOURCES; k++) shadow_kind[k] = KIND_FREE;
      shadow_offset = OFFSET_RESET;

      // Reset offset is 4096, so table entry i is global number 4096 + i.
      dir_rows.push_back(stim_row(CMD_FIND, 0, 1, 0, 0, 1, STATUS_OK, 16'd4096));
      dir_rows.push_back(stim_row(CMD_FIND, 0, 1024, 0, 0, 1, STATUS_OK, 16'd4096));
      dir_rows.push_back(stim_row(CMD_FIND, 0, 1025, 0, 0, 1, STATUS_NO_BLOCK, 0));
      dir_rows.push_back(stim_row(CMD_FIND, 0, 2047, 1, 0, 1, STATUS_INVALID, 0));
      dir_rows.push_back(stim_row(CMD_FIND, 0, 0, 0, 0, 1, STATUS_INVALID, 0));
      dir_rows.push_back(stim_row(CMD_FIND, 0, 3, 1, 0, 1, STATUS_INVALID, 0));
      dir_rows.push_back(stim_row(CMD_FIND, 0, 64, 1, 0, 1, STATUS_INVALID, 0));
      dir_rows.push_back(stim_row(CMD_CLAIM, 4096, 1, 0, 0, 1, STATUS_OK, 0));
      dir_rows.push_back(stim_row(CMD_CLAIM, 4096, 1, 0, 1, 1, STATUS_BUSY, 0));
      dir_rows.push_back(stim_row(CMD_CLAIM, 0, 1, 0, 0, 1, STATUS_INVALID, 0));
      dir_rows.push_back(stim_row(CMD_CLAIM, 65535, 1, 0, 1, 1, STATUS_INVALID, 0));
      dir_rows.push_back(stim_row(CMD_CLAIM, 5119, 1, 0, 1, 1, STATUS_OK, 0));
      dir_rows.push_back(stim_row(CMD_CLAIM, 5120, 1, 0, 0, 1, STATUS_INVALID, 0));
      dir_rows.push_back(stim_row(CMD_CLAIM, 4101, 1, 0, 1, 1, STATUS_OK, 0));
      dir_rows.push_back(stim_row(CMD_FIND, 0, 4, 1, 0, 0, STATUS_OK, 0));
      dir_rows.push_back(stim_row(CMD_FIND, 0, 4, 0, 0, 0, STATUS_OK, 0));
      dir_rows.push_back(stim_row(CMD_FIND, 0, 32, 1, 0, 0, STATUS_OK, 0));
      dir_rows.push_back(stim_row(CMD_FIND, 0, 1023, 0, 0, 0, STATUS_OK, 0));
      // A free that runs past the last entry stops at the end of the table.
      dir_rows.push_back(stim_row(CMD_FREE, 5116, 2047, 0, 0, 1, STATUS_OK, 0));
      dir_rows.push_back(stim_row(CMD_FREE, 4096, 0, 0, 0, 1, STATUS_OK, 0));
      dir_rows.push_back(stim_row(CMD_CLAIM, 4096, 1, 0, 0, 1, STATUS_BUSY, 0));
      dir_rows.push_back(stim_row(CMD_FREE, 4096, 8, 0, 0, 1, STATUS_OK, 0));
      dir_rows.push_back(stim_row(CMD_FREE, 65535, 1, 0, 0, 1, STATUS_INVALID, 0));
      dir_rows.push_back(stim_row(CMD_RESERVED, 65535, 2047, 1, 1, 1, STATUS_INVALID, 0));
      dir_rows.push_back(stim_row(CMD_FIND, 0, 1024, 0, 0, 1, STATUS_OK, 16'd4096));
      dir_rows.push_back(stim_row(CMD_CLAIM, 5119, 1, 0, 0, 1, STATUS_OK, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);

      // Offsets 0 and 65535 are the extremes; 65024 puts part of the table
      // above the top of the 16-bit number space.
      chunk_offset[0] = 16'd0;
      chunk_offset[1] = 16'hFFFF;
      chunk_offset[2] = 16'd700;
      chunk_offset[3] = 16'hFE00;
      chunk_offset[4] = NUM_W'($urandom_range(65535));
      chunk_offset[5] = OFFSET_RESET;

      for (k = 0; k < 6; k++) begin
         if (k < 2) begin
            send_idle_pct = 30;
            rsp_stall_pct = 69;
         end else if (k < 4) begin
            send_idle_pct = 69;
            rsp_stall_pct = 30;
         end else begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         // The block must be idle before irq_offset changes.
         drain_results();
         write_offset(chunk_offset[k]);
         for (n = 0; n < 93; n++) send_request(random_request(), 1'b0, '0);
      end

      drain_results();
      repeat (20) @(posedge clock);

      $display("Requests: %0d find, %0d claim, %0d free, %0d reserved command.",
               find_count, claim_count, free_count, other_count);
      $display("Responses checked: %0d, irq_offset settings written: %0d.",
               checked_count, offset_writes);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
